### rtl/psvp_pkg.sv
// ============================================================================
// psvp_pkg : shared widths and types for positional sound volume and pan
// Constants, pipeline word layout and cell interface types.
// ============================================================================
`default_nettype none
package psvp_pkg;
   localparam int CoordW = 16;
   localparam int DiffW  = CoordW + 1;
   localparam int SqW    = 2 * DiffW + 1;
   localparam int RootW  = (SqW + 1) / 2;
   localparam int ProdW  = 2 * CoordW + 3;
   localparam int NumW   = ProdW + 2;
   localparam int MagW   = NumW - 1;
   localparam int PanStg = 7;
   localparam int VolNear = 700;
   localparam int VolDiv  = 12;
   // floor(x/12) as (x * 2731) >> 15, exact for x below 8192
   localparam int VolRecip   = 2731;
   localparam int VolShift   = 15;
   // distance past the knee where the volume reaches its floor (239 * 12)
   localparam int VolFarOver = 2868;
   localparam logic [7:0] VolMax = 8'hFF;
   localparam logic [7:0] VolMin = 8'h10;

   // Word carried along the root chain.
   typedef struct packed {
      logic              valid;
      logic [15:0]       voice_id;
      logic              play;
      logic [RootW-1:0]  probe;
      logic [RootW-1:0]  dist_root;
      logic [RootW-1:0]  ref_root;
      logic [SqW-1:0]    dist_sq;
      logic [SqW-1:0]    ref_sq;
      logic signed [NumW-1:0] num;
   } root_word_type;

   // Word carried along the pan division chain.
   typedef struct packed {
      logic              valid;
      logic [15:0]       voice_id;
      logic              play;
      logic [7:0]        volume;
      logic              negative;
      logic              zero_ref;
      logic [MagW-1:0]   mag;
      logic [MagW-1:0]   div;
      logic [PanStg-1:0] quot;
   } pan_word_type;
endpackage
`default_nettype wire

### rtl/psvp_root_cell.sv
// ============================================================================
// psvp_root_cell : one bit of two parallel integer square roots
// Tries the probe bit for both roots: accepts if (root|bit)^2 <= square.
// ============================================================================
`default_nettype none
module psvp_root_cell
   import psvp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  root_word_type      word_in,
   output root_word_type      word_out
);
   root_word_type word_ff, word_in_c;
   logic [RootW-1:0] try_d, try_r;
   logic [2*RootW-1:0] sq_d, sq_r;

   always_comb begin
      word_in_c = word_in;
      try_d = word_in.dist_root | word_in.probe;
      try_r = word_in.ref_root  | word_in.probe;
      sq_d  = try_d * try_d;
      sq_r  = try_r * try_r;
      if (sq_d <= (2*RootW)'(word_in.dist_sq)) word_in_c.dist_root = try_d;
      if (sq_r <= (2*RootW)'(word_in.ref_sq))  word_in_c.ref_root  = try_r;
      word_in_c.probe = word_in.probe >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) word_ff.valid <= 1'b0;
      else       word_ff.valid <= word_in_c.valid;
      word_ff.voice_id  <= word_in_c.voice_id;
      word_ff.play      <= word_in_c.play;
      word_ff.probe     <= word_in_c.probe;
      word_ff.dist_root <= word_in_c.dist_root;
      word_ff.ref_root  <= word_in_c.ref_root;
      word_ff.dist_sq   <= word_in_c.dist_sq;
      word_ff.ref_sq    <= word_in_c.ref_sq;
      word_ff.num       <= word_in_c.num;
   end
   assign word_out = word_ff;
endmodule
`default_nettype wire

### rtl/psvp_div_cell.sv
// ============================================================================
// psvp_div_cell : one quotient bit of |num| / (16*dd)
// Restoring division step on the pan chain.
// ============================================================================
`default_nettype none
module psvp_div_cell
   import psvp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  pan_word_type   word_in,
   output pan_word_type   word_out
);
   pan_word_type word_ff, word_in_c;

   // divisor arrives pre-shifted for this bit and leaves shifted for the next
   always_comb begin
      word_in_c = word_in;
      if (word_in.mag >= word_in.div) begin
         word_in_c.mag  = word_in.mag - word_in.div;
         word_in_c.quot = {word_in.quot[PanStg-2:0], 1'b1};
      end else begin
         word_in_c.quot = {word_in.quot[PanStg-2:0], 1'b0};
      end
      word_in_c.div = word_in.div >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) word_ff.valid <= 1'b0;
      else       word_ff.valid <= word_in_c.valid;
      word_ff.voice_id <= word_in_c.voice_id;
      word_ff.play     <= word_in_c.play;
      word_ff.volume   <= word_in_c.volume;
      word_ff.negative <= word_in_c.negative;
      word_ff.zero_ref <= word_in_c.zero_ref;
      word_ff.mag      <= word_in_c.mag;
      word_ff.div      <= word_in_c.div;
      word_ff.quot     <= word_in_c.quot;
   end
   assign word_out = word_ff;
endmodule
`default_nettype wire

### rtl/positional_sound_volume_pan.sv
// ============================================================================
// positional_sound_volume_pan : distance volume and side pan for one voice
// Pipelined chain of root cells, then a chain of division cells.
// ============================================================================
// channel  | handshake        | payload
// request  | start / busy     | req_voice_id req_play req_source_* req_camera_* req_ref_*
// response | rsp_valid strobe | rsp_sound_out rsp_play_out rsp_volume rsp_pan
//
// One word accepted every cycle; busy is tied low.
// Pipeline: 1 input stage + RootW root cells + 1 volume stage + 7 division
// cells + 1 output stage, set by the length of the two cell chains.
// Synchronous reset clears only the valid bits of the chain.
// The receiver cannot stall: every result is shown for one cycle.
// ============================================================================
`default_nettype none
module positional_sound_volume_pan
   import psvp_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [15:0]              req_voice_id,
   input  wire logic                     req_play,
   input  wire logic signed [CoordW-1:0] req_source_x,
   input  wire logic signed [CoordW-1:0] req_source_z,
   input  wire logic signed [CoordW-1:0] req_camera_x,
   input  wire logic signed [CoordW-1:0] req_camera_z,
   input  wire logic signed [CoordW-1:0] req_ref_x,
   input  wire logic signed [CoordW-1:0] req_ref_z,
   output logic                          rsp_valid,
   output logic [15:0]                   rsp_sound_out,
   output logic                          rsp_play_out,
   output logic [7:0]                    rsp_volume,
   output logic signed [7:0]             rsp_pan
);
   assign busy = 1'b0;

   // ---- stage 0: differences and products, registered ----
   logic signed [DiffW-1:0] dx, dz, ez, ex;
   logic signed [ProdW-1:0] p0_in, p1_in, p2_in, p3_in;
   logic signed [ProdW-1:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic [SqW-1:0] dsq_in, rsq_in;
   logic [SqW-1:0] dx2_ff, dz2_ff, ez2_ff, ex2_ff;
   logic v0_ff;
   logic [15:0] id0_ff;
   logic play0_ff;

   always_comb begin
      dx = DiffW'(req_camera_x) - DiffW'(req_source_x);
      dz = DiffW'(req_camera_z) - DiffW'(req_source_z);
      ez = DiffW'(req_ref_z) - DiffW'(req_camera_z);
      ex = DiffW'(req_camera_x) - DiffW'(req_ref_x);
      p0_in = ProdW'(req_source_x) * ProdW'(ez);
      p1_in = ProdW'(req_source_z) * ProdW'(ex);
      p2_in = ProdW'(req_ref_x) * ProdW'(req_camera_z);
      p3_in = ProdW'(req_camera_x) * ProdW'(req_ref_z);
      dsq_in = SqW'(dx * dx);
      rsq_in = SqW'(ez * ez);
   end

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else       v0_ff <= start;
      id0_ff <= req_voice_id;
      play0_ff <= req_play;
      p0_ff <= p0_in; p1_ff <= p1_in; p2_ff <= p2_in; p3_ff <= p3_in;
      dx2_ff <= dsq_in;
      dz2_ff <= SqW'(dz * dz);
      ez2_ff <= rsq_in;
      ex2_ff <= SqW'(ex * ex);
   end

   // ---- root chain: probe bit walks from the top root bit down ----
   root_word_type rhead;
   root_word_type rchain [RootW+1];
   always_comb begin
      rhead = '0;
      rhead.valid    = v0_ff;
      rhead.voice_id = id0_ff;
      rhead.play     = play0_ff;
      rhead.probe    = RootW'(1) << (RootW - 1);
      rhead.dist_sq  = dx2_ff + dz2_ff;
      rhead.ref_sq   = ez2_ff + ex2_ff;
      rhead.num      = NumW'(p0_ff) + NumW'(p1_ff) + NumW'(p2_ff) - NumW'(p3_ff);
   end
   assign rchain[0] = rhead;

   for (genvar g = 0; g < RootW; g++) begin : g_root
      psvp_root_cell u_cell (
         .clock, .reset, .word_in(rchain[g]), .word_out(rchain[g+1]));
   end

   // ---- volume and division setup ----
   root_word_type rw;
   logic [RootW-1:0] over;
   logic [23:0] kprod;
   logic [7:0] kq;
   logic [7:0] vol_c;
   pan_word_type pset_in, pset_ff;
   assign rw = rchain[RootW];

   // past the floor point the quotient is never needed, so only the low
   // 12 bits of the excess go through the reciprocal multiply
   always_comb begin
      over  = rw.dist_root - RootW'(VolNear);
      kprod = 24'(over[11:0]) * 24'(VolRecip);
      kq    = kprod[VolShift +: 8];
      if (rw.dist_root <= RootW'(VolNear))    vol_c = VolMax;
      else if (over >= RootW'(VolFarOver))    vol_c = VolMin;
      else                                    vol_c = VolMax - kq;
      pset_in = '0;
      pset_in.valid    = rw.valid;
      pset_in.voice_id = rw.voice_id;
      pset_in.play     = rw.play;
      pset_in.volume   = vol_c;
      pset_in.negative = rw.num[NumW-1];
      pset_in.zero_ref = (rw.ref_root == '0);
      pset_in.mag      = rw.num[NumW-1] ? MagW'(-rw.num) : MagW'(rw.num);
      // 16*dd aligned to the top quotient bit
      pset_in.div      = MagW'(rw.ref_root) << (PanStg + 3);
   end

   always_ff @(posedge clock) begin
      if (reset) pset_ff.valid <= 1'b0;
      else       pset_ff.valid <= pset_in.valid;
      pset_ff.voice_id <= pset_in.voice_id;
      pset_ff.play     <= pset_in.play;
      pset_ff.volume   <= pset_in.volume;
      pset_ff.negative <= pset_in.negative;
      pset_ff.zero_ref <= pset_in.zero_ref;
      pset_ff.mag      <= pset_in.mag;
      pset_ff.div      <= pset_in.div;
      pset_ff.quot     <= pset_in.quot;
   end

   // ---- division chain: pan = |num| / (16*dd), 7 quotient bits ----
   pan_word_type pchain [PanStg+1];
   assign pchain[0] = pset_ff;
   for (genvar g = 0; g < PanStg; g++) begin : g_div
      psvp_div_cell u_cell (
         .clock, .reset, .word_in(pchain[g]), .word_out(pchain[g+1]));
   end

   // ---- output register ----
   pan_word_type pw;
   logic [7:0] pan_in;
   logic valid_ff, play_ff;
   logic [15:0] sound_ff;
   logic [7:0] vol_ff, pan_ff;
   assign pw = pchain[PanStg];

   always_comb begin
      if (pw.zero_ref)     pan_in = 8'h00;
      else if (pw.negative) pan_in = 8'(-{1'b0, pw.quot});
      else                 pan_in = {1'b0, pw.quot};
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= pw.valid;
      sound_ff <= pw.voice_id;
      play_ff  <= pw.play;
      vol_ff   <= pw.volume;
      pan_ff   <= pan_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_sound_out = sound_ff;
   assign rsp_play_out  = play_ff;
   assign rsp_volume    = vol_ff;
   assign rsp_pan       = pan_ff;

   // volume range and pan magnitude
   a_vol_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_volume >= VolMin) else $error("volume below floor");
   a_pan_rng: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pan != 8'h80) else $error("pan out of range");
   a_zero_ref: assert property (@(posedge clock) disable iff (reset)
      pw.valid && pw.zero_ref |=> rsp_pan == 8'h00) else $error("pan not centered");
endmodule
`default_nettype wire

### tb/sv/positional_sound_volume_pan_tb.sv
// ============================================================================
// positional_sound_volume_pan_tb : self-checking bench for volume and pan
// Drives geometry words through the start/busy port, predicts volume and pan
// with exact wide math, and checks every strobed result in order.
// ============================================================================
`timescale 1ns / 1ps
module positional_sound_volume_pan_tb;
   import psvp_pkg::*;

   typedef struct {
      logic [15:0] voice_id;
      logic        play;
      logic signed [CoordW-1:0] sx, sz, cx, cz, rx, rz;
   } voice_req_type;

   typedef struct {
      logic [15:0] sound_out;
      logic        play_out;
      logic [7:0]  volume;
      logic [7:0]  pan;
   } voice_mix_type;

   localparam int CycleLimit = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [15:0] req_voice_id = '0;
   logic req_play = 1'b0;
   logic signed [CoordW-1:0] req_source_x = '0, req_source_z = '0;
   logic signed [CoordW-1:0] req_camera_x = '0, req_camera_z = '0;
   logic signed [CoordW-1:0] req_ref_x = '0, req_ref_z = '0;
   logic rsp_valid;
   logic [15:0] rsp_sound_out;
   logic rsp_play_out;
   logic [7:0] rsp_volume;
   logic signed [7:0] rsp_pan;

   voice_req_type pending_reqs[$];
   voice_mix_type expected_mix[$];
   int errors = 0;
   int words_sent = 0;
   int words_checked = 0;
   int cycles = 0;
   int far_words = 0;
   int clipped_pans = 0;
   int zero_refs = 0;
   bit stim_done = 1'b0;
   bit no_idle = 1'b0;

   positional_sound_volume_pan dut (
      .clock, .reset, .start, .busy,
      .req_voice_id, .req_play,
      .req_source_x, .req_source_z, .req_camera_x, .req_camera_z,
      .req_ref_x, .req_ref_z,
      .rsp_valid, .rsp_sound_out, .rsp_play_out, .rsp_volume, .rsp_pan
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Floor square root of a nonnegative value; 128 bits is far beyond need.
   function automatic logic [63:0] isqrt(input logic [127:0] val);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 40; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (128'(trial) * 128'(trial) <= val) root = trial;
      end
      return root;
   endfunction

   // Expected volume and pan for one voice request.
   function automatic voice_mix_type mix_voice(input voice_req_type r);
      voice_mix_type m;
      longint dx, dz, ez, ex;
      logic signed [127:0] num;
      logic [127:0] num_mag;
      logic [63:0] src_dist, ref_len, q;
      dx = longint'(r.cx) - longint'(r.sx);
      dz = longint'(r.cz) - longint'(r.sz);
      ez = longint'(r.rz) - longint'(r.cz);
      ex = longint'(r.cx) - longint'(r.rx);
      m.sound_out = r.voice_id;
      m.play_out = r.play;
      src_dist = isqrt(128'(dx * dx) + 128'(dz * dz));
      if (src_dist > VolNear) begin
         q = (src_dist - VolNear) / VolDiv;
         m.volume = (q >= 239) ? VolMin : 8'(255 - q);
      end else begin
         m.volume = VolMax;
      end
      ref_len = isqrt(128'(ez * ez) + 128'(ex * ex));
      if (ref_len == 0) begin
         m.pan = 8'sd0;
      end else begin
         num = 128'(longint'(r.sx) * ez) + 128'(longint'(r.sz) * ex)
             + 128'(longint'(r.rx) * longint'(r.cz))
             - 128'(longint'(r.cx) * longint'(r.rz));
         num_mag = num[127] ? -num : num;
         q = 64'(num_mag / ref_len / 16);
         if (q > 127) q = 127;
         m.pan = num[127] ? 8'(-q) : 8'(q);
      end
      return m;
   endfunction

   task automatic report(input string what, input logic [15:0] got,
                         input logic [15:0] want);
      errors++;
      $display("MISMATCH %s at word %0d: got %0h want %0h", what, words_checked, got, want);
   endtask

   // Driver: pops one word per accepted handshake, idles in random bursts.
   int idle_left = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (start && !busy) words_sent++;
         if (start && busy) begin
            // word not taken yet: hold it
         end else if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 15) == 0) begin
            idle_left = $urandom_range(1, 18) - 1;
            start <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            voice_req_type r;
            r = pending_reqs.pop_front();
            expected_mix.push_back(mix_voice(r));
            req_voice_id <= r.voice_id;
            req_play <= r.play;
            req_source_x <= r.sx;
            req_source_z <= r.sz;
            req_camera_x <= r.cx;
            req_camera_z <= r.cz;
            req_ref_x <= r.rx;
            req_ref_z <= r.rz;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // A word is queued at the falling edge before the edge that takes it, so
   // the expectation always exists before its result can appear.
   // Monitor: every strobed result is checked against the oldest expectation.
   always @(posedge clock) begin
      cycles++;
      if (!reset && rsp_valid) begin
         if (expected_mix.size() == 0) begin
            report("unexpected result", rsp_sound_out, 16'h0000);
         end else begin
            voice_mix_type e;
            e = expected_mix.pop_front();
            if (rsp_sound_out !== e.sound_out) report("sound_out", rsp_sound_out, e.sound_out);
            if (rsp_play_out !== e.play_out) report("play_out", rsp_play_out, e.play_out);
            if (rsp_volume !== e.volume) report("volume", rsp_volume, e.volume);
            if (rsp_pan !== e.pan) report("pan", rsp_pan, e.pan);
            if (e.volume == VolMin) far_words++;
            if (e.pan == 8'h7F || e.pan == 8'h81) clipped_pans++;
            words_checked++;
         end
      end
      if (cycles > CycleLimit) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic signed [CoordW-1:0] rnd_coord(input int span);
      if (span == 0) return CoordW'($urandom);
      return CoordW'($urandom_range(0, 2 * span) - span);
   endfunction

   task automatic add_req(input logic signed [CoordW-1:0] sx, sz, cx, cz, rx, rz);
      voice_req_type r;
      r.voice_id = 16'($urandom);
      r.play = 1'($urandom);
      r.sx = sx; r.sz = sz; r.cx = cx; r.cz = cz; r.rx = rx; r.rz = rz;
      if (rx == cx && rz == cz) zero_refs++;
      pending_reqs.push_back(r);
   endtask

   localparam logic signed [CoordW-1:0] CMax = {1'b0, {(CoordW-1){1'b1}}};
   localparam logic signed [CoordW-1:0] CMin = {1'b1, {(CoordW-1){1'b0}}};

   initial begin
      int span;
      voice_req_type r;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes, near/far boundary, zero reference length, clipping.
      add_req(0, 0, 0, 0, 0, 0);
      add_req(CMax, CMax, CMin, CMin, CMax, CMin);
      add_req(CMin, CMin, CMax, CMax, CMin, CMax);
      add_req(CMin, CMax, CMax, CMin, CMin, CMin);
      add_req(700, 0, 0, 0, 0, 100);
      add_req(701, 0, 0, 0, 0, 100);
      add_req(712, 0, 0, 0, 0, 100);
      add_req(713, 0, 0, 0, 0, 100);
      add_req(3568, 0, 0, 0, 0, 100);
      add_req(3569, 0, 0, 0, 0, 100);
      add_req(500, 500, 10, 10, 10, 10);
      add_req(-2032, 0, 0, 0, 0, 1);
      add_req(-2047, 0, 0, 0, 0, 1);
      add_req(2047, 0, 0, 0, 0, 1);
      add_req(20000, 0, 0, 0, 0, 1);
      add_req(-20000, 0, 0, 0, 0, 1);
      add_req(5, 5, 1, 1, 2, 2);
      r.voice_id = 16'hFFFF; r.play = 1'b1;
      r.sx = CMax; r.sz = CMin; r.cx = 0; r.cz = 0; r.rx = 1; r.rz = 0;
      pending_reqs.push_back(r);
      r.voice_id = 16'h0000; r.play = 1'b0;
      pending_reqs.push_back(r);

      // Random: mostly small spans so volume and pan land in range, some full.
      for (int i = 0; i < 1650; i++) begin
         case ($urandom_range(0, 3))
            0: span = 0;
            1: span = 4000;
            2: span = 800;
            default: span = 30;
         endcase
         if ($urandom_range(0, 19) == 0) begin
            logic signed [CoordW-1:0] cx, cz;
            cx = rnd_coord(span); cz = rnd_coord(span);
            add_req(rnd_coord(span), rnd_coord(span), cx, cz, cx, cz);
         end else begin
            add_req(rnd_coord(span), rnd_coord(span), rnd_coord(span),
                    rnd_coord(span), rnd_coord(span), rnd_coord(span));
         end
         // Back-to-back stretch for the last part of the run.
         if (i == 1400) begin
            wait (pending_reqs.size() == 0);
            no_idle = 1'b1;
         end
      end

      wait (pending_reqs.size() == 0 && expected_mix.size() == 0);
      repeat (4 * RootW + 40) @(posedge clock);
      $display("Sent %0d words, checked %0d: %0d at minimum volume, %0d clipped pans",
               words_sent, words_checked, far_words, clipped_pans);
      $display("Covered coordinate extremes, volume breakpoints, %0d zero refs and idle gaps",
               zero_refs);
      if (errors == 0 && expected_mix.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

### files.f
rtl/psvp_pkg.sv
rtl/psvp_root_cell.sv
rtl/psvp_div_cell.sv
rtl/positional_sound_volume_pan.sv
tb/sv/positional_sound_volume_pan_tb.sv
